@@ design/epp_pkg.sv @@
// Shared types and constants for the ellipse phantom pixel generator.
// No dependencies.
package epp_pkg;

	localparam int CoordW = 11;
	localparam int ValW   = 20;
	localparam int NumEll = 10;
	localparam int AccW   = 26;

	typedef enum logic [1:0] {
		K_ONE   = 2'd0,
		K_DARK  = 2'd1,
		K_GREY  = 2'd2,
		K_LIGHT = 2'd3
	} kind_t;

	// per-ellipse shape in thousandths of size
	typedef struct packed {
		logic        neg_x;
		logic [9:0]  off_x;
		logic        neg_y;
		logic [9:0]  off_y;
		logic [9:0]  ax;
		logic [9:0]  by;
		kind_t       kind;
	} shape_t;

	// geometry of one ellipse in pixels
	typedef struct packed {
		logic [11:0] cx;
		logic [11:0] cy;
		logic [10:0] a;
		logic [10:0] b;
		logic [AccW-1:0] inten;
	} geom_t;

	// request traveling down the chain of cells
	typedef struct packed {
		logic             vld;
		logic [CoordW-1:0] px;
		logic [CoordW-1:0] py;
		logic              oob;
		logic [ValW-1:0]   base;
		logic signed [AccW-1:0] acc;
	} req_t;

	localparam int CfgAddrW = 5;
	localparam logic [CfgAddrW-1:0] A_CX = 5'd0;
	localparam logic [CfgAddrW-1:0] A_CY = 5'd4;
	localparam logic [CfgAddrW-1:0] A_SZ = 5'd8;
	localparam logic [CfgAddrW-1:0] A_HC = 5'd12;
	localparam logic [CfgAddrW-1:0] A_OW = 5'd16;

	function automatic shape_t shape_of(input int i);
		shape_t s;
		s = '0;
		unique case (i)
			0: s = '{1'b0, 10'd0,   1'b0, 10'd0,   10'd375, 10'd500, K_ONE};
			1: s = '{1'b0, 10'd0,   1'b0, 10'd10,  10'd360, 10'd475, K_DARK};
			2: s = '{1'b0, 10'd112, 1'b0, 10'd0,   10'd60,  10'd168, K_GREY};
			3: s = '{1'b1, 10'd112, 1'b0, 10'd0,   10'd87,  10'd223, K_GREY};
			4: s = '{1'b0, 10'd0,   1'b1, 10'd190, 10'd114, 10'd136, K_LIGHT};
			5: s = '{1'b0, 10'd0,   1'b0, 10'd54,  10'd25,  10'd25,  K_LIGHT};
			6: s = '{1'b0, 10'd0,   1'b1, 10'd54,  10'd25,  10'd25,  K_LIGHT};
			7: s = '{1'b1, 10'd43,  1'b0, 10'd329, 10'd25,  10'd13,  K_LIGHT};
			8: s = '{1'b0, 10'd0,   1'b0, 10'd329, 10'd13,  10'd13,  K_LIGHT};
			default: s = '{1'b0, 10'd33, 1'b0, 10'd329, 10'd13, 10'd25, K_LIGHT};
		endcase
		return s;
	endfunction

	// intensity in signed Q9.16
	function automatic logic [AccW-1:0] inten_of(input kind_t k, input logic hc);
		logic signed [AccW-1:0] v;
		v = '0;
		unique case (k)
			K_ONE:   v = AccW'(65536);
			K_DARK:  v = hc ? -AccW'(52429) : -AccW'(32113);
			K_GREY:  v = hc ? -AccW'(13107) : -AccW'(655);
			default: v = hc ? AccW'(6554) : AccW'(328);
		endcase
		return v;
	endfunction

endpackage

@@ design/epp_geom.sv @@
// Per-ellipse geometry from the configuration: scaled centers and semi-axes.
// Uses epp_pkg. Registered; recomputed after each configuration write.
module epp_geom #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic [epp_pkg::CoordW-1:0] center_x,
	input  logic [epp_pkg::CoordW-1:0] center_y,
	input  logic [epp_pkg::CoordW-1:0] phantom_size,
	input  logic                       contrast_sel,
	output epp_pkg::geom_t             geom
);
	localparam epp_pkg::shape_t S = epp_pkg::shape_of(IDX);
	// floor(v/1000) for v < 2^21 via reciprocal 2^30/1000 rounded up
	localparam logic [20:0] Recip = 21'd1073742;

	logic [20:0] px_s1, py_s1, pa_s1, pb_s1;
	logic [10:0] sx, sy;
	logic [12:0] cxw, cyw;
	logic [41:0] mx, my, ma, mb;

	// scale products, then divide by 1000 next cycle
	always_ff @(posedge clk) begin
		px_s1 <= phantom_size * S.off_x;
		py_s1 <= phantom_size * S.off_y;
		pa_s1 <= phantom_size * S.ax;
		pb_s1 <= phantom_size * S.by;
	end

	always_comb begin
		mx = px_s1 * Recip;
		my = py_s1 * Recip;
		ma = pa_s1 * Recip;
		mb = pb_s1 * Recip;
		sx = mx[40:30];
		sy = my[40:30];
		cxw = S.neg_x ? ({2'b0, center_x} - {2'b0, sx}) : ({2'b0, center_x} + {2'b0, sx});
		cyw = S.neg_y ? ({2'b0, center_y} - {2'b0, sy}) : ({2'b0, center_y} + {2'b0, sy});
	end

	// clamp negative centers to zero
	always_ff @(posedge clk) begin
		geom.cx    <= cxw[12] ? 12'd0 : cxw[11:0];
		geom.cy    <= cyw[12] ? 12'd0 : cyw[11:0];
		geom.a     <= ma[40:30];
		geom.b     <= mb[40:30];
		geom.inten <= epp_pkg::inten_of(S.kind, contrast_sel);
	end
endmodule

@@ design/epp_cell.sv @@
// One cell of the ellipse chain: tests a pixel against one ellipse over four
// stages and adds its intensity. Uses epp_pkg.
module epp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  epp_pkg::geom_t geom,
	input  epp_pkg::req_t  req_in,
	output epp_pkg::req_t  req_out
);
	epp_pkg::req_t r_s1, r_s2, r_s3;
	logic [11:0] dx_s1, dy_s1;
	logic [21:0] a2_s1, b2_s1, a2_s2, b2_s2;
	logic [23:0] dx2_s2, dy2_s2;
	logic [45:0] t1_s3, t2_s3, t3_s3;
	logic [12:0] dxw, dyw;
	logic        in_c;

	// absolute offsets from the center
	always_comb begin
		dxw = {2'b0, req_in.px} - {1'b0, geom.cx};
		dyw = {2'b0, req_in.py} - {1'b0, geom.cy};
	end

	// advance request: squares, then cross products, then compare and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_s1 <= '0;
			r_s2 <= '0;
			r_s3 <= '0;
			req_out <= '0;
			dx_s1 <= '0;
			dy_s1 <= '0;
			a2_s1 <= '0;
			b2_s1 <= '0;
			dx2_s2 <= '0;
			dy2_s2 <= '0;
			a2_s2 <= '0;
			b2_s2 <= '0;
			t1_s3 <= '0;
			t2_s3 <= '0;
			t3_s3 <= '0;
		end else begin
			r_s1 <= req_in;
			dx_s1 <= dxw[12] ? 12'(-dxw) : dxw[11:0];
			dy_s1 <= dyw[12] ? 12'(-dyw) : dyw[11:0];
			a2_s1 <= geom.a * geom.a;
			b2_s1 <= geom.b * geom.b;
			r_s2 <= r_s1;
			dx2_s2 <= dx_s1 * dx_s1;
			dy2_s2 <= dy_s1 * dy_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			r_s3 <= r_s2;
			t1_s3 <= dx2_s2 * b2_s2;
			t2_s3 <= dy2_s2 * a2_s2;
			t3_s3 <= a2_s2 * b2_s2;
			{req_out.vld, req_out.px, req_out.py, req_out.oob, req_out.base} <=
				{r_s3.vld, r_s3.px, r_s3.py, r_s3.oob, r_s3.base};
			req_out.acc <= in_c ? r_s3.acc + $signed(geom.inten) : r_s3.acc;
		end
	end

	assign in_c = ({1'b0, t1_s3} + {1'b0, t2_s3}) <= {1'b0, t3_s3};
endmodule

@@ design/ellipse_phantom_pixel_generator.sv @@
// Top level of the ellipse phantom pixel generator: config registers,
// a chain of ten ellipse cells and the saturating output. Uses epp_pkg, epp_geom, epp_cell.
//
// channel   | signals                                   | flow
// ----------+-------------------------------------------+----------------------
// request   | start, busy, pixel_x, pixel_y, base_value | in, one per cycle
// result    | done, pixel_value                         | out, one-cycle strobe
// config    | psel penable pwrite paddr pwdata prdata   | APB, pready always 1
//
// One request per cycle; each result passes through an entry register, ten cells
// of four stages and an exit register.
// busy is always low. Reset clears the request pipeline and done, and sets the config registers to their defaults.
// The result strobe cannot be stalled. Geometry settles through the product and geometry
// registers of epp_geom after a configuration write.
module ellipse_phantom_pixel_generator #(
	parameter int MAX_DIM = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [epp_pkg::CoordW-1:0]  pixel_x,
	input  logic [epp_pkg::CoordW-1:0]  pixel_y,
	input  logic signed [epp_pkg::ValW-1:0] base_value,
	output logic                        done,
	output logic signed [epp_pkg::ValW-1:0] pixel_value,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [epp_pkg::CfgAddrW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	localparam int N = epp_pkg::NumEll;
	localparam logic [12:0] MaxD = 13'(MAX_DIM);

	logic [10:0] cx_q, cy_q, sz_q;
	logic        hc_q, ow_q;
	logic        wr;
	epp_pkg::geom_t geom [N];
	epp_pkg::req_t  chain [N+1];
	epp_pkg::req_t  last;
	logic signed [epp_pkg::AccW-1:0] acc;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= 11'd512;
			cy_q <= 11'd512;
			sz_q <= 11'd512;
			hc_q <= 1'b0;
			ow_q <= 1'b1;
		end else if (wr) begin
			unique case (paddr)
				epp_pkg::A_CX: cx_q <= pwdata[10:0];
				epp_pkg::A_CY: cy_q <= pwdata[10:0];
				epp_pkg::A_SZ: sz_q <= pwdata[10:0];
				epp_pkg::A_HC: hc_q <= pwdata[0];
				epp_pkg::A_OW: ow_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			epp_pkg::A_CX: prdata = {21'd0, cx_q};
			epp_pkg::A_CY: prdata = {21'd0, cy_q};
			epp_pkg::A_SZ: prdata = {21'd0, sz_q};
			epp_pkg::A_HC: prdata = {31'd0, hc_q};
			epp_pkg::A_OW: prdata = {31'd0, ow_q};
			default:       prdata = '0;
		endcase
	end

	// entry register: range check and starting sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else begin
			chain[0].vld  <= start;
			chain[0].px   <= pixel_x;
			chain[0].py   <= pixel_y;
			chain[0].base <= base_value;
			chain[0].oob  <= (pixel_x == '0) || ({2'b0, pixel_x} > MaxD) ||
				(pixel_y == '0) || ({2'b0, pixel_y} > MaxD);
			chain[0].acc  <= ow_q ? '0 : epp_pkg::AccW'(base_value);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		epp_geom #(.IDX(i)) u_geom (
			.clk(clk), .center_x(cx_q), .center_y(cy_q),
			.phantom_size(sz_q), .contrast_sel(hc_q), .geom(geom[i])
		);
		epp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .geom(geom[i]),
			.req_in(chain[i]), .req_out(chain[i+1])
		);
	end

	assign last = chain[N];
	assign acc  = last.acc;

	// drive the result: out-of-range pixels return the base value, others saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= last.vld;
	end
	always_ff @(posedge clk) begin
		if (last.oob) pixel_value <= last.base;
		else if (acc > epp_pkg::AccW'(524287)) pixel_value <= 20'sd524287;
		else if (acc < -epp_pkg::AccW'(524288)) pixel_value <= -20'sd524288;
		else pixel_value <= acc[epp_pkg::ValW-1:0];
	end

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].vld |-> ##41 done) else $error("result lost");
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		(last.vld && last.oob) |=> (pixel_value == $past(last.base)))
		else $error("out of range pixel changed");
endmodule

@@ verif/tb_ellipse_phantom_pixel_generator.sv @@
// Self-checking bench for ellipse_phantom_pixel_generator: drives pixel requests,
// predicts every phantom pixel value and checks the result strobes in order.
// Depends on epp_pkg and the design top level.
module tb_ellipse_phantom_pixel_generator;

	localparam int MaxDim     = 1024;
	localparam int CycleLimit = 400000;
	localparam int NumPhases  = 10;
	localparam int PhaseItems = 135;

	typedef struct {
		logic [epp_pkg::CoordW-1:0]      x;
		logic [epp_pkg::CoordW-1:0]      y;
		logic signed [epp_pkg::ValW-1:0] base;
	} pixel_req_t;

	typedef struct {
		logic [10:0] cx;
		logic [10:0] cy;
		logic [10:0] size;
		logic        hc;
		logic        ow;
	} phantom_cfg_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [epp_pkg::CoordW-1:0]      pixel_x;
	logic [epp_pkg::CoordW-1:0]      pixel_y;
	logic signed [epp_pkg::ValW-1:0] base_value;
	logic                            done;
	logic signed [epp_pkg::ValW-1:0] pixel_value;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [epp_pkg::CfgAddrW-1:0]    paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	pixel_req_t                      pixel_req_q[$];
	logic signed [epp_pkg::ValW-1:0] pixel_value_q[$];
	phantom_cfg_t                    cfg;
	int                              send_idle_pct;
	int                              cycle_cnt;
	bit                              failed;

	// ellipse table in thousandths of size: offsets signed, semi-axes, kind
	int ell_off_x[epp_pkg::NumEll] = '{0, 0, 112, -112, 0, 0, 0, -43, 0, 33};
	int ell_off_y[epp_pkg::NumEll] = '{0, 10, 0, 0, -190, 54, -54, 329, 329, 329};
	int ell_ax[epp_pkg::NumEll]    = '{375, 360, 60, 87, 114, 25, 25, 25, 13, 13};
	int ell_by[epp_pkg::NumEll]    = '{500, 475, 168, 223, 136, 25, 25, 13, 13, 25};
	epp_pkg::kind_t ell_kind[epp_pkg::NumEll] = '{epp_pkg::K_ONE, epp_pkg::K_DARK,
		epp_pkg::K_GREY, epp_pkg::K_GREY, epp_pkg::K_LIGHT, epp_pkg::K_LIGHT,
		epp_pkg::K_LIGHT, epp_pkg::K_LIGHT, epp_pkg::K_LIGHT, epp_pkg::K_LIGHT};

	ellipse_phantom_pixel_generator #(.MAX_DIM(MaxDim)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .base_value(base_value),
		.done(done), .pixel_value(pixel_value),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	function automatic longint scaled_len(input longint size, input int milli);
		return (size * milli) / 1000;
	endfunction

	function automatic longint shade_of(input epp_pkg::kind_t k, input logic hc);
		case (k)
			epp_pkg::K_ONE:  return 65536;
			epp_pkg::K_DARK: return hc ? -52429 : -32113;
			epp_pkg::K_GREY: return hc ? -13107 : -655;
			default:         return hc ? 6554 : 328;
		endcase
	endfunction

	// out-of-range pixels keep the prior value; else sum the covering ellipses onto zero or the prior value, saturate once
	function automatic logic signed [epp_pkg::ValW-1:0] phantom_pixel(input pixel_req_t r);
		longint acc, ctr_x, ctr_y, a, b, dx, dy;
		if (r.x < 1 || r.x > MaxDim || r.y < 1 || r.y > MaxDim)
			return r.base;
		acc = cfg.ow ? 0 : longint'(r.base);
		for (int i = 0; i < epp_pkg::NumEll; i++) begin
			ctr_x = (ell_off_x[i] < 0) ? cfg.cx - scaled_len(cfg.size, -ell_off_x[i])
				: cfg.cx + scaled_len(cfg.size, ell_off_x[i]);
			ctr_y = (ell_off_y[i] < 0) ? cfg.cy - scaled_len(cfg.size, -ell_off_y[i])
				: cfg.cy + scaled_len(cfg.size, ell_off_y[i]);
			if (ctr_x < 0) ctr_x = 0;
			if (ctr_y < 0) ctr_y = 0;
			a = scaled_len(cfg.size, ell_ax[i]);
			b = scaled_len(cfg.size, ell_by[i]);
			dx = longint'(r.x) - ctr_x;
			dy = longint'(r.y) - ctr_y;
			if (dx * dx * b * b + dy * dy * a * a <= a * a * b * b)
				acc += shade_of(ell_kind[i], cfg.hc);
		end
		if (acc > 524287) acc = 524287;
		if (acc < -524288) acc = -524288;
		return epp_pkg::ValW'(acc);
	endfunction

	// one APB transfer; reads are checked against the shadow copy
	task automatic apb_xfer(input logic wr, input logic [epp_pkg::CfgAddrW-1:0] addr,
			input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (!wr && prdata !== data) begin
			$error("register %0d: expected %0h, actual %0h", addr, data, prdata);
			failed = 1'b1;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_cfg(input phantom_cfg_t c);
		cfg = c;
		apb_xfer(1'b1, epp_pkg::A_CX, 32'(c.cx));
		apb_xfer(1'b1, epp_pkg::A_CY, 32'(c.cy));
		apb_xfer(1'b1, epp_pkg::A_SZ, 32'(c.size));
		apb_xfer(1'b1, epp_pkg::A_HC, 32'(c.hc));
		apb_xfer(1'b1, epp_pkg::A_OW, 32'(c.ow));
		// read back; this also covers the geometry settling time
		apb_xfer(1'b0, epp_pkg::A_CX, 32'(c.cx));
		apb_xfer(1'b0, epp_pkg::A_CY, 32'(c.cy));
		apb_xfer(1'b0, epp_pkg::A_SZ, 32'(c.size));
		apb_xfer(1'b0, epp_pkg::A_HC, 32'(c.hc));
		apb_xfer(1'b0, epp_pkg::A_OW, 32'(c.ow));
	endtask

	task automatic push_pixel(input int x, input int y, input int base);
		pixel_req_t r;
		r.x = epp_pkg::CoordW'(x);
		r.y = epp_pkg::CoordW'(y);
		r.base = epp_pkg::ValW'(base);
		pixel_req_q.push_back(r);
	endtask

	// mostly near the phantom, sometimes anywhere in the coordinate range
	function automatic int pick_coord(input int ctr);
		int span, v;
		if ($urandom_range(99) < 20)
			return $urandom_range(2047);
		span = cfg.size * 6 / 10 + 2;
		v = ctr - span + int'($urandom_range(2 * span));
		return (v < 0) ? 0 : (v > 2047 ? 2047 : v);
	endfunction

	task automatic drain_all();
		@(negedge clk);
		while (pixel_req_q.size() != 0 || start || pixel_value_q.size() != 0)
			@(negedge clk);
	endtask

	// present requests; record the prediction at each accept
	always @(posedge clk) begin
		if (start && !busy) begin
			pixel_value_q.push_back(phantom_pixel('{pixel_x, pixel_y, base_value}));
			void'(pixel_req_q.pop_front());
		end
		if (pixel_req_q.size() > (start && !busy ? 1 : 0)
				&& $urandom_range(99) >= send_idle_pct) begin
			pixel_req_t nxt;
			nxt = (start && !busy) ? pixel_req_q[1] : pixel_req_q[0];
			start <= 1'b1;
			pixel_x <= nxt.x;
			pixel_y <= nxt.y;
			base_value <= nxt.base;
		end else begin
			start <= 1'b0;
		end
	end

	// compare each result strobe with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pixel_value_q.size() == 0) begin
				$error("pixel_value: no request pending, actual %0d", pixel_value);
				failed = 1'b1;
			end else begin
				logic signed [epp_pkg::ValW-1:0] want;
				want = pixel_value_q.pop_front();
				if (pixel_value !== want) begin
					$error("pixel_value: expected %0d, actual %0d", want, pixel_value);
					failed = 1'b1;
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("ellipse_phantom_pixel_generator: mismatch");
			$finish;
		end
	end

	initial begin
		phantom_cfg_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		base_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycle_cnt = 0;
		failed = 1'b0;
		send_idle_pct = 12;
		cfg = '{11'd512, 11'd512, 11'd512, 1'b0, 1'b1};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, out-of-image pixels, field extremes
		push_pixel(512, 512, 0);
		push_pixel(0, 512, -524288);
		push_pixel(512, 0, 524287);
		push_pixel(1025, 512, 12345);
		push_pixel(512, 2047, -1);
		push_pixel(2047, 2047, 0);
		push_pixel(1, 1, 524287);
		push_pixel(1024, 1024, -524288);
		push_pixel(1, 1024, 0);
		push_pixel(512, 342, 0);
		push_pixel(455, 512, 0);
		push_pixel(569, 512, 0);
		push_pixel(512, 680, 0);
		drain_all();

		// directed: add onto the prior value, saturating both ways
		load_cfg('{11'd512, 11'd512, 11'd512, 1'b1, 1'b0});
		push_pixel(512, 512, 524287);
		push_pixel(512, 500, -524288);
		push_pixel(512, 300, -524288);
		push_pixel(2000, 5, 100);
		push_pixel(455, 512, 524000);
		drain_all();

		// directed: zero size makes every ellipse cover the whole image
		load_cfg('{11'd0, 11'd1024, 11'd0, 1'b0, 1'b1});
		push_pixel(1, 1, 0);
		push_pixel(1024, 17, 0);
		push_pixel(0, 1024, 77);
		drain_all();

		// random phases, extreme settings first
		for (int ph = 0; ph < NumPhases; ph++) begin
			send_idle_pct = (ph < 4) ? 12 : (ph < 7 ? 51 : 0);
			case (ph)
				0: c = '{11'd0, 11'd0, 11'd1024, 1'b1, 1'b0};
				1: c = '{11'd1024, 11'd1024, 11'd1024, 1'b0, 1'b1};
				2: c = '{11'd1024, 11'd0, 11'd1, 1'b1, 1'b1};
				default: begin
					c.cx = 11'($urandom_range(1024));
					c.cy = 11'($urandom_range(1024));
					c.size = 11'($urandom_range(99) < 80 ? $urandom_range(16, 1024)
						: $urandom_range(15));
					c.hc = 1'($urandom);
					c.ow = 1'($urandom);
				end
			endcase
			load_cfg(c);
			for (int k = 0; k < PhaseItems; k++)
				push_pixel(pick_coord(cfg.cx), pick_coord(cfg.cy),
					int'(epp_pkg::ValW'($urandom)));
			drain_all();
		end

		repeat (60) @(posedge clk);
		if (!failed && pixel_value_q.size() == 0)
			$display("ellipse_phantom_pixel_generator: match");
		else
			$display("ellipse_phantom_pixel_generator: mismatch");
		$finish;
	end

endmodule
